FILE: rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, codes and sizes for the ARP cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Configuration port geometry: one 32-bit register.
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Register indexes.
  localparam logic REG_OWN_IP = 1'b0;

  // ARP opcode for a request.
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_LEARN   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_RECEIVE = 2'd2
  } cmd_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] ip_address;
    logic [47:0] hw_address;
    logic [15:0] arp_opcode;
    logic [31:0] tpa_address;
    logic        frame_short;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic        resolve_hit;
    logic [47:0] found_mac;
    logic        frame_dropped;
    logic        reply_send;
    logic [47:0] reply_dest_mac;
    logic [31:0] reply_dest_ip;
  } result_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

FILE: rtl/core/arpc_regs.sv
// ----------------------------------------------------------------------------
// ARP cache configuration registers
// APB-style slave holding the station's own IPv4 address.
// ----------------------------------------------------------------------------
module arpc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpc_pkg::APB_AW-1:0]  paddr,
  input  logic [arpc_pkg::APB_DW-1:0]  pwdata,
  output logic [arpc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [31:0]                  own_ip_o
);
  import arpc_pkg::*;

  logic        wr_en;
  logic        reg_idx;
  logic [31:0] own_ip_q;
  logic [31:0] own_ip_d;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write decode; writes beyond the register list are ignored.
  always_comb begin
    own_ip_d = own_ip_q;
    if (wr_en && (reg_idx == REG_OWN_IP)) begin
      own_ip_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else begin
      own_ip_q <= own_ip_d;
    end
  end

  // Read back.
  assign prdata   = (reg_idx == REG_OWN_IP) ? own_ip_q : '0;
  assign own_ip_o = own_ip_q;

endmodule

FILE: rtl/core/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Two-state sequencer: capture a command, then run it against the table.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output arpc_pkg::dp_cmd_t dp_cmd_o
);
  import arpc_pkg::*;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    dp_cmd_o.load = 1'b0;
    dp_cmd_o.exec = 1'b0;
    busy          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          dp_cmd_o.load = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy          = 1'b1;
        dp_cmd_o.exec = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An accepted beat is executed in the very next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> dp_cmd_o.exec)
    else $error("accepted command was not executed");

endmodule

FILE: rtl/core/arpc_dp.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Command capture, associative table with parallel match, and result register.
// ----------------------------------------------------------------------------
module arpc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arpc_pkg::dp_cmd_t dp_cmd_i,
  input  arpc_pkg::item_t   item_i,
  input  logic [31:0]       own_ip_i,
  output arpc_pkg::result_t result_o,
  output logic              result_strobe_o
);
  import arpc_pkg::*;

  item_t               item_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [ENTRIES-1:0]  valid_d;
  logic [31:0]         entry_ip_q  [ENTRIES];
  logic [47:0]         entry_mac_q [ENTRIES];
  logic [ENTRIES-1:0]  match;
  logic                any_match;
  logic                any_free;
  logic [IDX_W-1:0]    match_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic                store_en;
  logic                is_request;
  result_t             result_d;
  result_t             result_q;
  logic                strobe_q;

  // Capture the command beat when it is accepted.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Parallel compare against every valid entry.
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match[k] = valid_q[k] && (entry_ip_q[k] == item_q.ip_address);
    end
  end

  // Lowest matching slot and lowest free slot.
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        any_match = 1'b1;
        match_idx = IDX_W'(k);
      end
      if (!valid_q[k]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
  end

  // Store target: matching entry, else first free slot, else slot zero.
  assign wr_idx   = any_match ? match_idx : (any_free ? free_idx : '0);
  assign store_en = dp_cmd_i.exec &&
                    ((item_q.cmd == CMD_LEARN) ||
                     ((item_q.cmd == CMD_RECEIVE) && !item_q.frame_short));

  // Table payload, written at one address.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      entry_ip_q[wr_idx]  <= item_q.ip_address;
      entry_mac_q[wr_idx] <= item_q.hw_address;
    end
  end

  // Valid bits, cleared by reset.
  always_comb begin
    valid_d = valid_q;
    if (store_en) begin
      valid_d[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result composition; fields a command does not produce stay zero.
  assign is_request = (item_q.arp_opcode == OPCODE_REQUEST) &&
                      (item_q.tpa_address == own_ip_i);

  always_comb begin
    result_d = '0;
    case (item_q.cmd)
      CMD_RESOLVE: begin
        if (any_match) begin
          result_d.resolve_hit = 1'b1;
          result_d.found_mac   = entry_mac_q[match_idx];
        end
      end
      CMD_RECEIVE: begin
        if (item_q.frame_short) begin
          result_d.frame_dropped = 1'b1;
        end else if (is_request) begin
          result_d.reply_send     = 1'b1;
          result_d.reply_dest_mac = item_q.hw_address;
          result_d.reply_dest_ip  = item_q.ip_address;
        end
      end
      default: begin
        result_d = '0;
      end
    endcase
  end

  // Result register and strobe.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= dp_cmd_i.exec;
    end
  end

  assign result_o        = result_q;
  assign result_strobe_o = strobe_q;

  // An IP address is never held by two valid entries.
  a_unique_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.exec |-> $onehot0(match))
    else $error("duplicate IP in table");

  // A result beat carries the outcome of one command kind only.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !(result_o.resolve_hit && result_o.reply_send) &&
                        !(result_o.frame_dropped && result_o.reply_send))
    else $error("result mixes command outcomes");

  // A miss reports no MAC.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.resolve_hit) |-> (result_o.found_mac == '0))
    else $error("MAC reported without a hit");

endmodule

FILE: rtl/core/arp_cache_responder_top.sv
// ----------------------------------------------------------------------------
// ARP cache responder
// 16-entry IPv4-to-MAC cache with learn, resolve and ARP receive commands.
//
//   Channel   Handshake                         Beat
//   command   start in, busy out                item_i   (arpc_pkg::item_t)
//   result    result_strobe_o, one cycle        result_o (arpc_pkg::result_t)
//   config    APB psel/penable/pwrite, pready   own_ip at byte address 0
//
// A command is taken when start is high and busy is low. busy is high for
// the one execute cycle that follows, in which the table is searched in
// parallel and updated; the result beat appears in the cycle after that.
// No new command is taken while busy is high, during the execute cycle.
// Reset empties the table and clears own_ip. Results cannot be stalled.
// ----------------------------------------------------------------------------
module arp_cache_responder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  arpc_pkg::item_t              item_i,
  output arpc_pkg::result_t            result_o,
  output logic                         result_strobe_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpc_pkg::APB_AW-1:0]  paddr,
  input  logic [arpc_pkg::APB_DW-1:0]  pwdata,
  output logic [arpc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import arpc_pkg::*;

  dp_cmd_t     dp_cmd;
  logic [31:0] own_ip;

  // Configuration registers.
  arpc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .own_ip_o (own_ip)
  );

  // Sequencer.
  arpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .dp_cmd_o (dp_cmd)
  );

  // Table and result datapath.
  arpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .item_i          (item_i),
    .own_ip_i        (own_ip),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

FILE: tb/sv/arp_cache_monitor.sv
// ----------------------------------------------------------------------------
// ARP cache monitor
// Watches the command, result and configuration channels of the ARP cache
// responder. It keeps its own copy of the address table and of own_ip,
// predicts one result beat per accepted command, and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module arp_cache_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  arpc_pkg::item_t               item_i,
  input  arpc_pkg::result_t             result_i,
  input  logic                          result_strobe_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpc_pkg::APB_AW-1:0]   paddr,
  input  logic [arpc_pkg::APB_DW-1:0]   pwdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            hits_o,
  output int                            replies_o,
  output int                            drops_o,
  output int                            evictions_o
);
  import arpc_pkg::*;

  // Shadow copy of the cache table and the station address.
  logic [31:0] cache_ip    [ENTRIES];
  logic [47:0] cache_mac   [ENTRIES];
  logic        cache_valid [ENTRIES];
  logic [31:0] station_ip;

  // Result beats that the block still owes, oldest first.
  result_t     predicted_beats [$];
  result_t     oldest_beat;
  int          clr_idx;

  // Writes a sender pair: update a matching entry, else take the lowest
  // free slot, else evict slot 0.
  task automatic cache_store(input logic [31:0] ip, input logic [47:0] mac);
    int slot;
    slot = -1;
    for (int k = 0; k < ENTRIES; k++) begin
      if (slot < 0 && cache_valid[k] && cache_ip[k] == ip) begin
        slot = k;
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      if (slot < 0 && !cache_valid[k]) begin
        slot = k;
      end
    end
    if (slot < 0) begin
      slot = 0;
      evictions_o++;
    end
    cache_ip[slot]    = ip;
    cache_mac[slot]   = mac;
    cache_valid[slot] = 1'b1;
  endtask

  // Executes one command on the shadow table and returns the beat it yields.
  task automatic run_arp_command(input item_t cmd_beat, output result_t res);
    res = '0;
    case (cmd_beat.cmd)
      CMD_LEARN: begin
        cache_store(cmd_beat.ip_address, cmd_beat.hw_address);
      end
      CMD_RESOLVE: begin
        for (int k = ENTRIES - 1; k >= 0; k--) begin
          if (cache_valid[k] && cache_ip[k] == cmd_beat.ip_address) begin
            res.resolve_hit = 1'b1;
            res.found_mac   = cache_mac[k];
          end
        end
        if (res.resolve_hit) begin
          hits_o++;
        end
      end
      CMD_RECEIVE: begin
        if (cmd_beat.frame_short) begin
          res.frame_dropped = 1'b1;
          drops_o++;
        end else begin
          cache_store(cmd_beat.ip_address, cmd_beat.hw_address);
          if (cmd_beat.arp_opcode == OPCODE_REQUEST &&
              cmd_beat.tpa_address == station_ip) begin
            res.reply_send     = 1'b1;
            res.reply_dest_mac = cmd_beat.hw_address;
            res.reply_dest_ip  = cmd_beat.ip_address;
            replies_o++;
          end
        end
      end
      default: begin
        // The unused command code leaves the table alone.
      end
    endcase
  endtask

  task automatic note_mismatch(input string fname, input logic [47:0] want,
                               input logic [47:0] got);
    if (got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("[%0t] result beat %0d, %s: expected %h, got %h",
                 $realtime, checked_o, fname, want, got);
      end
    end
  endtask

  // Everything happens on the rising edge, in the order: result check,
  // command prediction, register write.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (clr_idx = 0; clr_idx < ENTRIES; clr_idx++) begin
        cache_ip[clr_idx]    = '0;
        cache_mac[clr_idx]   = '0;
        cache_valid[clr_idx] = 1'b0;
      end
      station_ip = '0;
      predicted_beats.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      hits_o       = 0;
      replies_o    = 0;
      drops_o      = 0;
      evictions_o  = 0;
    end else begin
      // Compare a result beat with the oldest prediction.
      if (result_strobe_i) begin
        if (predicted_beats.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("[%0t] result beat with no command outstanding: %h",
                     $realtime, result_i);
          end
        end else begin
          oldest_beat = predicted_beats.pop_front();
          note_mismatch("resolve_hit", 48'(oldest_beat.resolve_hit), 48'(result_i.resolve_hit));
          note_mismatch("found_mac", oldest_beat.found_mac, result_i.found_mac);
          note_mismatch("frame_dropped", 48'(oldest_beat.frame_dropped),
                        48'(result_i.frame_dropped));
          note_mismatch("reply_send", 48'(oldest_beat.reply_send), 48'(result_i.reply_send));
          note_mismatch("reply_dest_mac", oldest_beat.reply_dest_mac, result_i.reply_dest_mac);
          note_mismatch("reply_dest_ip", 48'(oldest_beat.reply_dest_ip),
                        48'(result_i.reply_dest_ip));
        end
        checked_o++;
      end

      // Predict the beat for a command accepted at this edge.
      if (start && !busy) begin
        run_arp_command(item_i, oldest_beat);
        predicted_beats.push_back(oldest_beat);
      end

      // Register writes; only own_ip exists, other indexes are dropped.
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == REG_OWN_IP) begin
          station_ip = pwdata[31:0];
        end
      end

      pending_o = predicted_beats.size();
    end
  end

endmodule

FILE: tb/sv/arp_cache_responder_top_test.sv
// ----------------------------------------------------------------------------
// ARP cache responder testbench
// Drives learn, resolve, receive and unused commands into the responder,
// first a directed set of corner cases and then random phases under several
// own_ip settings. Addresses come mostly from a small pool so that lookups
// hit, the table fills and slot 0 gets evicted. The monitor does all
// checking; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module arp_cache_responder_top_test;
  import arpc_pkg::*;

  localparam int unsigned REG_SPARE_IDX = 1;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [15:0] OPCODE_REPLY  = 16'd2;
  localparam int          POOL_SIZE     = 24;
  localparam int          PHASE_ITEMS   = 200;
  localparam int          CYCLE_LIMIT   = 100000;
  localparam logic [31:0] FIRST_OWN_IP  = 32'hC0A8_0001;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  result_t             result_o;
  logic                result_strobe_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  hits;
  int                  replies;
  int                  drops;
  int                  evictions;

  logic [31:0]         ip_pool [POOL_SIZE];
  logic [31:0]         cur_own_ip;
  logic [31:0]         phase_own_ip [7];
  int                  sent;
  int                  cycles;

  arp_cache_responder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  arp_cache_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_i        (result_o),
    .result_strobe_i (result_strobe_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .hits_o          (hits),
    .replies_o       (replies),
    .drops_o         (drops),
    .evictions_o     (evictions)
  );

  // Clock with a period of 12.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic item_t arp_cmd(input logic [1:0] cmd, input logic [31:0] ip,
                                    input logic [47:0] mac, input logic [15:0] op,
                                    input logic [31:0] tip, input logic short_frame);
    item_t it;
    it.cmd         = cmd;
    it.ip_address  = ip;
    it.hw_address  = mac;
    it.arp_opcode  = op;
    it.tpa_address = tip;
    it.frame_short = short_frame;
    return it;
  endfunction

  // Random command; most addresses come from the pool so the table stays busy.
  function automatic item_t random_arp_cmd();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.cmd = CMD_LEARN;
    end else if (pick < 55) begin
      it.cmd = CMD_RESOLVE;
    end else if (pick < 95) begin
      it.cmd = CMD_RECEIVE;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    it.ip_address = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    it.hw_address = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.arp_opcode = OPCODE_REQUEST;
    end else if (pick < 85) begin
      it.arp_opcode = OPCODE_REPLY;
    end else begin
      it.arp_opcode = 16'($urandom);
    end
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      it.tpa_address = cur_own_ip;
    end else if (pick == 2) begin
      it.tpa_address = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      it.tpa_address = 32'($urandom);
    end
    it.frame_short = ($urandom_range(0, 6) == 0);
    return it;
  endfunction

  // Sends one command beat. Entered and left at a falling edge; start stays
  // high on exit so that back-to-back beats need no toggle.
  task automatic send_arp_cmd(input item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent++;
  endtask

  // Drops start and waits until every result beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic reg_write(input int unsigned idx, input logic [31:0] value);
    logic [APB_AW-1:0] addr;
    addr = APB_AW'(idx << 2);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Corner cases: empty table, address extremes, updates, unused command,
  // short frames, opcodes other than request, ignored fields set.
  task automatic directed_arp_cmds();
    send_arp_cmd(arp_cmd(CMD_RESOLVE, 32'h0, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, '1, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_LEARN, 32'h0, 48'h0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, 32'h0, '1, '1, '1, 1'b1));
    send_arp_cmd(arp_cmd(CMD_LEARN, '1, '1, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, '1, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_LEARN, '1, 48'h1234_5678_9ABC, '1, '1, 1'b1));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, '1, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_UNUSED, '1, '1, OPCODE_REQUEST, FIRST_OWN_IP, 1'b1));
    send_arp_cmd(arp_cmd(CMD_UNUSED, '0, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, 32'h0A00_0005, 48'hAABB_CCDD_EEFF, OPCODE_REQUEST,
                         FIRST_OWN_IP, 1'b1));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, 32'h0A00_0005, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, 32'h0A00_0006, 48'h0011_2233_4455, OPCODE_REQUEST,
                         FIRST_OWN_IP, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, 32'h0A00_0006, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, 32'h0A00_0007, '1, OPCODE_REQUEST,
                         FIRST_OWN_IP ^ 32'h1, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, '1, 48'h8000_0000_0001, OPCODE_REPLY, FIRST_OWN_IP,
                         1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, 32'h0A00_0008, 48'h1, '1, FIRST_OWN_IP, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RECEIVE, '1, '1, OPCODE_REQUEST, FIRST_OWN_IP, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, '1, '0, '0, '0, 1'b0));
    send_arp_cmd(arp_cmd(CMD_RESOLVE, 32'h0A00_0007, '0, '0, '0, 1'b0));
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    item_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sent    = 0;

    // Address pool: both extremes plus random addresses.
    ip_pool[0] = 32'h0;
    ip_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      ip_pool[k] = $urandom;
    end
    phase_own_ip[0] = 32'h0;
    phase_own_ip[1] = '1;
    phase_own_ip[2] = ip_pool[5];
    phase_own_ip[3] = $urandom;
    phase_own_ip[4] = ip_pool[2];
    phase_own_ip[5] = 32'h8000_0001;
    phase_own_ip[6] = ip_pool[9];

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with a write to a register index that does not exist.
    reg_write(REG_OWN_IP, FIRST_OWN_IP);
    cur_own_ip = FIRST_OWN_IP;
    reg_write(REG_SPARE_IDX, '1);
    directed_arp_cmds();

    // Random phases, one own_ip setting each.
    for (int p = 0; p < 7; p++) begin
      drain_results();
      reg_write(REG_OWN_IP, phase_own_ip[p]);
      cur_own_ip = phase_own_ip[p];
      repeat (PHASE_ITEMS) send_arp_cmd(random_arp_cmd());
    end
    drain_results();

    $display("Sent %0d commands over 8 own_ip settings; %0d result beats checked.",
             sent, checked);
    $display("Resolve hits %0d, replies %0d, short frames %0d, slot 0 evictions %0d.",
             hits, replies, drops, evictions);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", fail_count, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
